// ===== hw/rtl/cptl_pkg.sv =====
// Package for the C preprocessor token lexer: token kinds, lexer modes,
// result record, keyword and operator tables. No dependencies.
package cptl_pkg;

	localparam int OFFSET_BITS_DEF   = 16;
	localparam int MAX_TOKEN_LEN_DEF = 255;
	localparam int OFFSET_MAX        = 32;
	localparam int LEN_MAX           = 16;
	localparam int NUM_KW            = 13;
	localparam int RES_PER_ITEM      = 3;
	localparam int Q_DEPTH           = 8;
	localparam int Q_AW              = $clog2(Q_DEPTH);

	typedef enum logic [2:0] {
		K_NEWLINE   = 3'd0,
		K_DIRECTIVE = 3'd1,
		K_IDENT     = 3'd2,
		K_NUMBER    = 3'd3,
		K_RESERVED  = 3'd4,
		K_CHAR      = 3'd5,
		K_STRING    = 3'd6,
		K_EOF       = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		E_NONE     = 2'd0,
		E_QUOTE    = 2'd1,
		E_BLOCKCMT = 2'd2
	} err_t;

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_NUMBER, M_DQUOTE, M_SQUOTE, M_LINECMT,
		M_BLOCKCMT, M_BLOCKSTAR, M_SLASH, M_BACKSL, M_OP1, M_DOT2
	} mode_t;

	typedef struct packed {
		kind_t                 kind;
		logic [OFFSET_MAX-1:0] start;
		logic [LEN_MAX-1:0]    len;
		logic                  blank;
		err_t                  err;
		logic                  last;
	} res_t;

	function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] pos);
		logic [103:0] w;
		logic [7:0]   ch;
		case (k)
			4'd0:    w = {"include", "_next", 8'h00};
			4'd1:    w = {"include", 48'h0};
			4'd2:    w = {"define", 56'h0};
			4'd3:    w = {"undef", 64'h0};
			4'd4:    w = {"defined", 48'h0};
			4'd5:    w = {"warning", 48'h0};
			4'd6:    w = {"error", 64'h0};
			4'd7:    w = {"ifdef", 64'h0};
			4'd8:    w = {"ifndef", 56'h0};
			4'd9:    w = {"if", 88'h0};
			4'd10:   w = {"else", 72'h0};
			4'd11:   w = {"elif", 72'h0};
			4'd12:   w = {"endif", 64'h0};
			default: w = '0;
		endcase
		ch = 8'h00;
		for (int i = 0; i < 13; i++)
			if (pos == 4'(i))
				ch = w[103-8*i -: 8];
		return ch;
	endfunction

	function automatic logic [3:0] kw_len(input logic [3:0] k);
		logic [3:0] l;
		case (k)
			4'd0:    l = 4'd12;
			4'd1:    l = 4'd7;
			4'd2:    l = 4'd6;
			4'd3:    l = 4'd5;
			4'd4:    l = 4'd7;
			4'd5:    l = 4'd7;
			4'd6:    l = 4'd5;
			4'd7:    l = 4'd5;
			4'd8:    l = 4'd6;
			4'd9:    l = 4'd2;
			4'd10:   l = 4'd4;
			4'd11:   l = 4'd4;
			4'd12:   l = 4'd5;
			default: l = 4'd0;
		endcase
		return l;
	endfunction

	function automatic logic pair_starter(input logic [7:0] c);
		return c == ">" || c == "<" || c == "=" || c == "!" || c == "-" || c == "+" ||
			c == "&" || c == "|" || c == "%" || c == "/" || c == "*" || c == "#";
	endfunction

	function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
		logic p;
		case ({a, b})
			">>", "<<", "==", "!=", "<=", ">=", "--", "++",
			"&&", "||", "+=", "-=", "%=", "/=", "*=", "##": p = 1'b1;
			default: p = 1'b0;
		endcase
		return p;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

endpackage

// ===== hw/rtl/cptl_if.sv =====
// Channel interfaces of the token lexer: text byte input and token output.
interface cptl_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;
	modport source (output valid, text_byte, end_of_text, input ready);
	modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface cptl_tok_if #(parameter int OFFSET_BITS = 16, parameter int LEN_BITS = 8);
	logic                   valid;
	logic                   ready;
	logic [2:0]             token_kind;
	logic [OFFSET_BITS-1:0] start_offset;
	logic [LEN_BITS-1:0]    token_length;
	logic                   spaces_before;
	logic [1:0]             error_code;
	logic                   last_of_run;
	modport source (output valid, token_kind, start_offset, token_length, spaces_before,
		error_code, last_of_run, input ready);
	modport sink (input valid, token_kind, start_offset, token_length, spaces_before,
		error_code, last_of_run, output ready);
endinterface

// ===== hw/rtl/cptl_core.sv =====
// Lexer state and one-byte step logic; yields up to three results per item.
// Depends on cptl_pkg.
module cptl_core import cptl_pkg::*; #(
	parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
	parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
	parameter int LEN_BITS      = $clog2(MAX_TOKEN_LEN + 1)
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output res_t       res [RES_PER_ITEM],
	output logic [1:0] res_n
);

	localparam logic [LEN_BITS-1:0] LMAX = LEN_BITS'(MAX_TOKEN_LEN);

	mode_t                mode_q;
	kind_t                prev_q;
	logic [OFFSET_BITS-1:0] start_q, off_q;
	logic [LEN_BITS-1:0]  len_q;
	logic                 blank_q, esc_q;
	logic [7:0]           la_q;
	logic [NUM_KW-1:0]    mask_q;

	mode_t                mode;
	kind_t                prev;
	logic [OFFSET_BITS-1:0] start, off, o;
	logic [LEN_BITS-1:0]  len;
	logic                 blank, esc, do_idle;
	logic [7:0]           la, c;
	logic [NUM_KW-1:0]    mask;
	logic [1:0]           n;
	err_t                 eerr;
	res_t                 r [RES_PER_ITEM];

	function automatic logic [LEN_BITS-1:0] sat_inc(input logic [LEN_BITS-1:0] v);
		return (v < LMAX) ? v + 1'b1 : LMAX;
	endfunction

	function automatic res_t mk(input kind_t k, input logic [OFFSET_BITS-1:0] s,
		input logic [LEN_BITS-1:0] l, input logic b, input err_t e);
		res_t x;
		x.kind  = k;
		x.start = OFFSET_MAX'(s);
		x.len   = LEN_MAX'(l);
		x.blank = b;
		x.err   = e;
		x.last  = 1'b0;
		return x;
	endfunction

	function automatic logic [NUM_KW-1:0] kw_upd(input logic [NUM_KW-1:0] m,
		input logic [LEN_BITS-1:0] pos, input logic [7:0] ch);
		logic [NUM_KW-1:0] q;
		q = m;
		for (int k = 0; k < NUM_KW; k++)
			if (pos >= LEN_BITS'(13) || kw_char(4'(k), pos[3:0]) != ch)
				q[k] = 1'b0;
		return q;
	endfunction

	always_comb begin
		mode = mode_q; prev = prev_q; start = start_q; off = off_q; len = len_q;
		blank = blank_q; esc = esc_q; la = la_q; mask = mask_q;
		c = text_byte; o = off_q; n = 2'd0; do_idle = 1'b0; eerr = E_NONE;
		for (int i = 0; i < RES_PER_ITEM; i++)
			r[i] = '0;
		if (end_of_text) begin
			case (mode_q)
				M_IDENT: begin
					r[n] = mk(K_IDENT, start_q, len_q, blank, E_NONE);
					for (int k = 0; k < NUM_KW; k++)
						if (mask_q[k] && LEN_BITS'(kw_len(4'(k))) == len_q)
							r[n].kind = K_RESERVED;
					n = n + 1'b1; blank = 1'b0;
				end
				M_NUMBER: begin
					r[n] = mk(K_NUMBER, start_q, len_q, blank, E_NONE); n = n + 1'b1;
					blank = 1'b0;
				end
				M_DQUOTE, M_SQUOTE: begin
					r[n] = mk((mode_q == M_DQUOTE) ? K_STRING : K_CHAR, start_q, len_q,
						blank, E_QUOTE);
					n = n + 1'b1; blank = 1'b0;
				end
				M_BLOCKCMT, M_BLOCKSTAR: eerr = E_BLOCKCMT;
				M_SLASH, M_BACKSL, M_OP1: begin
					r[n] = mk(K_RESERVED, start_q, LEN_BITS'(1), blank, E_NONE);
					n = n + 1'b1; blank = 1'b0;
				end
				M_DOT2: begin
					r[n] = mk(K_RESERVED, start_q, LEN_BITS'(1), blank, E_NONE);
					n = n + 1'b1;
					r[n] = mk(K_RESERVED, start_q + 1'b1, LEN_BITS'(1), 1'b0, E_NONE);
					n = n + 1'b1; blank = 1'b0;
				end
				default: ;
			endcase
			r[n] = mk(K_EOF, off_q, '0, blank, eerr); n = n + 1'b1;
			prev = K_EOF; mode = M_IDLE; off = '0; blank = 1'b0; esc = 1'b0;
			len = '0; mask = '1;
		end else begin
			off = off_q + 1'b1;
			case (mode_q)
				M_IDENT: begin
					if (is_alpha(c) || is_digit(c)) begin
						mask = kw_upd(mask_q, len_q, c);
						len = sat_inc(len_q);
					end else begin
						r[n] = mk(K_IDENT, start_q, len_q, blank, E_NONE);
						for (int k = 0; k < NUM_KW; k++)
							if (mask_q[k] && LEN_BITS'(kw_len(4'(k))) == len_q)
								r[n].kind = K_RESERVED;
						prev = r[n].kind; n = n + 1'b1; blank = 1'b0;
						mask = '1; do_idle = 1'b1;
					end
				end
				M_NUMBER: begin
					if (is_digit(c)) begin
						len = sat_inc(len_q);
					end else if (c == "L" || c == "F") begin
						r[n] = mk(K_NUMBER, start_q, sat_inc(len_q), blank, E_NONE);
						n = n + 1'b1; blank = 1'b0; prev = K_NUMBER; mode = M_IDLE;
					end else begin
						r[n] = mk(K_NUMBER, start_q, len_q, blank, E_NONE);
						n = n + 1'b1; blank = 1'b0; prev = K_NUMBER; do_idle = 1'b1;
					end
				end
				M_DQUOTE, M_SQUOTE: begin
					if (esc_q) begin
						esc = 1'b0; len = sat_inc(len_q);
					end else if (c == ((mode_q == M_DQUOTE) ? 8'h22 : 8'h27)) begin
						r[n] = mk((mode_q == M_DQUOTE) ? K_STRING : K_CHAR, start_q, len_q,
							blank, E_NONE);
						prev = r[n].kind; n = n + 1'b1; blank = 1'b0; mode = M_IDLE;
					end else begin
						if (c == 8'h5c)
							esc = 1'b1;
						len = sat_inc(len_q);
					end
				end
				M_LINECMT: if (c == 8'h0a) do_idle = 1'b1;
				M_BLOCKCMT: if (c == "*") mode = M_BLOCKSTAR;
				M_BLOCKSTAR: begin
					if (c == "/")
						mode = M_IDLE;
					else if (c != "*")
						mode = M_BLOCKCMT;
				end
				M_SLASH: begin
					if (c == "/") begin
						mode = M_LINECMT;
					end else if (c == "*") begin
						mode = M_BLOCKCMT;
					end else if (c == "=") begin
						r[n] = mk(K_RESERVED, start_q, LEN_BITS'(2), blank, E_NONE);
						n = n + 1'b1; blank = 1'b0; prev = K_RESERVED; mode = M_IDLE;
					end else begin
						r[n] = mk(K_RESERVED, start_q, LEN_BITS'(1), blank, E_NONE);
						n = n + 1'b1; blank = 1'b0; prev = K_RESERVED; do_idle = 1'b1;
					end
				end
				M_BACKSL: begin
					if (c == 8'h0a) begin
						blank = 1'b1; mode = M_IDLE;
					end else begin
						r[n] = mk(K_RESERVED, start_q, LEN_BITS'(1), blank, E_NONE);
						n = n + 1'b1; blank = 1'b0; prev = K_RESERVED; do_idle = 1'b1;
					end
				end
				M_OP1: begin
					if (la_q == "." && c == ".") begin
						mode = M_DOT2;
					end else if (is_pair(la_q, c)) begin
						r[n] = mk(K_RESERVED, start_q, LEN_BITS'(2), blank, E_NONE);
						n = n + 1'b1; blank = 1'b0; prev = K_RESERVED; mode = M_IDLE;
					end else begin
						r[n] = mk(K_RESERVED, start_q, LEN_BITS'(1), blank, E_NONE);
						n = n + 1'b1; blank = 1'b0; prev = K_RESERVED; do_idle = 1'b1;
					end
				end
				M_DOT2: begin
					if (c == ".") begin
						r[n] = mk(K_RESERVED, start_q, LEN_BITS'(3), blank, E_NONE);
						n = n + 1'b1; blank = 1'b0; prev = K_RESERVED; mode = M_IDLE;
					end else begin
						r[n] = mk(K_RESERVED, start_q, LEN_BITS'(1), blank, E_NONE);
						n = n + 1'b1;
						r[n] = mk(K_RESERVED, start_q + 1'b1, LEN_BITS'(1), 1'b0, E_NONE);
						n = n + 1'b1; blank = 1'b0; prev = K_RESERVED; do_idle = 1'b1;
					end
				end
				default: do_idle = 1'b1;
			endcase
			if (do_idle) begin
				mode = M_IDLE;
				start = o;
				if (c == " " || c == 8'h09) begin
					blank = 1'b1;
				end else if (c == "/") begin
					mode = M_SLASH;
				end else if (c == 8'h5c) begin
					mode = M_BACKSL;
				end else if (c == "#" && (prev == K_NEWLINE || prev == K_EOF)) begin
					r[n] = mk(K_DIRECTIVE, o, LEN_BITS'(1), blank, E_NONE);
					n = n + 1'b1; blank = 1'b0; prev = K_DIRECTIVE;
				end else if (c == 8'h0a) begin
					r[n] = mk(K_NEWLINE, o, LEN_BITS'(1), blank, E_NONE);
					n = n + 1'b1; blank = 1'b0; prev = K_NEWLINE;
				end else if (c == 8'h22 || c == 8'h27) begin
					mode  = (c == 8'h22) ? M_DQUOTE : M_SQUOTE;
					start = o + 1'b1;
					len   = '0;
					esc   = 1'b0;
				end else if (is_digit(c)) begin
					mode = M_NUMBER; len = LEN_BITS'(1);
				end else if (is_alpha(c)) begin
					mode = M_IDENT;
					mask = kw_upd('1, '0, c);
					len  = LEN_BITS'(1);
				end else if (c == "." || pair_starter(c)) begin
					mode = M_OP1; la = c;
				end else begin
					r[n] = mk(K_RESERVED, o, LEN_BITS'(1), blank, E_NONE);
					n = n + 1'b1; blank = 1'b0; prev = K_RESERVED;
				end
			end
		end
		if (n != 2'd0)
			r[n - 1'b1].last = 1'b1;
	end

	assign res   = r;
	assign res_n = acc ? n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			prev_q  <= K_NEWLINE;
			start_q <= '0;
			off_q   <= '0;
			len_q   <= '0;
			blank_q <= 1'b0;
			esc_q   <= 1'b0;
			mask_q  <= '1;
		end else if (acc) begin
			mode_q  <= mode;
			prev_q  <= prev;
			start_q <= start;
			off_q   <= off;
			len_q   <= len;
			blank_q <= blank;
			esc_q   <= esc;
			mask_q  <= mask;
		end
	end

	always_ff @(posedge clk)
		if (acc)
			la_q <= la;

endmodule

// ===== hw/rtl/cptl_outq.sv =====
// Result queue: takes up to three results per cycle, hands out one per item.
// Depends on cptl_pkg.
module cptl_outq import cptl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  res_t       wr_data [RES_PER_ITEM],
	input  logic [1:0] wr_n,
	output logic       room,
	output logic       rd_valid,
	input  logic       rd_ready,
	output res_t       rd_data
);

	res_t            mem [Q_DEPTH];
	logic [Q_AW-1:0] wp_q, rp_q;
	logic [Q_AW:0]   cnt_q;
	logic            pop;

	assign room     = cnt_q <= (Q_AW+1)'(Q_DEPTH - RES_PER_ITEM);
	assign rd_valid = cnt_q != '0;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem[rp_q];

	always_ff @(posedge clk)
		for (int i = 0; i < RES_PER_ITEM; i++)
			if (2'(i) < wr_n)
				mem[wp_q + Q_AW'(i)] <= wr_data[i];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + Q_AW'(wr_n);
			rp_q  <= rp_q + Q_AW'(pop);
			cnt_q <= cnt_q + (Q_AW+1)'(wr_n) - (Q_AW+1)'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (Q_AW+1)'(Q_DEPTH))
		else $error("result queue overfilled");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n) (wr_n != 2'd0) |-> room)
		else $error("push without room");
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_n != 2'd0) |-> wr_data[wr_n - 1'b1].last)
		else $error("final result of an item lacks last mark");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_valid && rd_ready && wr_n == 2'd0) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count mismatch");
`endif

endmodule

// ===== hw/rtl/c_preprocessor_token_lexer.sv =====
// C preprocessor token lexer, top level.
// Takes one source byte per item on text_in and emits tokens on tok_out.
// Depends on cptl_pkg, cptl_if, cptl_core and cptl_outq.
//
// text_in carries text_byte and end_of_text; an end item flushes the open
// token and emits EOF, after which offsets restart at zero.
// tok_out carries one token per item; last_of_run marks the final token
// caused by one input item (at most three tokens per input item).
// A token is written into the result queue when the input item that closes
// it is accepted. Throughput: one input byte per cycle while the result
// queue holds room for three tokens; the output side drains one token a cycle.
// When the receiver stalls, tokens collect in the eight-entry queue and
// text_in ready drops once fewer than three entries are free.
// Reset (arst_n low) empties the queue and returns the lexer to idle with
// offset zero and the previous token taken as a newline.
module c_preprocessor_token_lexer import cptl_pkg::*; #(
	parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
	parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
	parameter int LEN_BITS      = $clog2(MAX_TOKEN_LEN + 1)
) (
	input logic         clk,
	input logic         arst_n,
	cptl_text_if.sink   text_in,
	cptl_tok_if.source  tok_out
);

	res_t       res [RES_PER_ITEM];
	res_t       head;
	logic [1:0] res_n;
	logic       room, acc;

	assign text_in.ready = room;
	assign acc = text_in.valid && room;

	cptl_core #(
		.OFFSET_BITS   (OFFSET_BITS),
		.MAX_TOKEN_LEN (MAX_TOKEN_LEN),
		.LEN_BITS      (LEN_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.acc         (acc),
		.text_byte   (text_in.text_byte),
		.end_of_text (text_in.end_of_text),
		.res         (res),
		.res_n       (res_n)
	);

	cptl_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (res),
		.wr_n     (res_n),
		.room     (room),
		.rd_valid (tok_out.valid),
		.rd_ready (tok_out.ready),
		.rd_data  (head)
	);

	assign tok_out.token_kind    = head.kind;
	assign tok_out.start_offset  = head.start[OFFSET_BITS-1:0];
	assign tok_out.token_length  = head.len[LEN_BITS-1:0];
	assign tok_out.spaces_before = head.blank;
	assign tok_out.error_code    = head.err;
	assign tok_out.last_of_run   = head.last;

endmodule

// ===== tb/cptl_lexer_check.sv =====
// Token checker for the C preprocessor token lexer: watches both channels, predicts
// the tokens of every accepted text item and compares them in order.
// Depends on cptl_pkg and cptl_if.
module cptl_lexer_check import cptl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	cptl_text_if txt,
	cptl_tok_if  tok,
	output int   n_fail,
	output int   n_waiting,
	output int   n_tokens,
	output int   n_texts
);

	typedef struct {
		kind_t      kind;
		logic [15:0] start;
		logic [7:0] len;
		logic       blank;
		err_t       err;
		logic       last;
	} token_rec_t;

	token_rec_t tokens_due[$];
	token_rec_t step_toks[$];

	string kw_words[NUM_KW] = '{{"include", "_next"}, "include", "define", "undef", "defined",
		"warning", "error", "ifdef", "ifndef", "if", "else", "elif", "endif"};

	mode_t       st_mode;
	kind_t       prev_tok;
	logic [15:0] tstart;
	int          tlen;
	logic        blank;
	logic        esc;
	logic [7:0]  op_first;
	logic [12:0] kw_mask;
	logic [15:0] offs;

	assign n_waiting = tokens_due.size();

	function automatic int sat_inc(int v);
		return v < 255 ? v + 1 : 255;
	endfunction

	function automatic bit digit_c(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit alpha_c(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit op_pair(logic [7:0] a, logic [7:0] b);
		string ops;
		ops = ">><<==!=<=>=--++&&||+=-=%=/=*=##";
		for (int i = 0; i < ops.len(); i += 2)
			if (ops[i] == a && ops[i+1] == b)
				return 1;
		return 0;
	endfunction

	function automatic bit op_starter(logic [7:0] c);
		string ops;
		ops = ">><<==!=<=>=--++&&||+=-=%=/=*=##";
		for (int i = 0; i < ops.len(); i += 2)
			if (ops[i] == c)
				return 1;
		return 0;
	endfunction

	task automatic push_tok(kind_t k, logic [15:0] s, int l, err_t e);
		token_rec_t r;
		r.kind = k;
		r.start = s;
		r.len = l[7:0];
		r.blank = blank;
		r.err = e;
		r.last = 1'b0;
		if (step_toks.size() < 4)
			step_toks.push_back(r);
		blank = 1'b0;
		prev_tok = k;
	endtask

	task automatic kw_narrow(int pos, logic [7:0] c);
		for (int k = 0; k < NUM_KW; k++)
			if (pos >= kw_words[k].len() || kw_words[k][pos] != c)
				kw_mask[k] = 1'b0;
	endtask

	task automatic close_word();
		kind_t k;
		k = K_IDENT;
		for (int i = 0; i < NUM_KW; i++)
			if (kw_mask[i] && kw_words[i].len() == tlen)
				k = K_RESERVED;
		push_tok(k, tstart, tlen, E_NONE);
		kw_mask = '1;
	endtask

	task automatic start_tok(logic [7:0] c, logic [15:0] o);
		st_mode = M_IDLE;
		tstart = o;
		if (c == " " || c == "\t")
			blank = 1'b1;
		else if (c == "/")
			st_mode = M_SLASH;
		else if (c == "\\")
			st_mode = M_BACKSL;
		else if (c == "#" && (prev_tok == K_NEWLINE || prev_tok == K_EOF))
			push_tok(K_DIRECTIVE, o, 1, E_NONE);
		else if (c == "\n")
			push_tok(K_NEWLINE, o, 1, E_NONE);
		else if (c == "\"" || c == "'") begin
			st_mode = c == "\"" ? M_DQUOTE : M_SQUOTE;
			tstart = o + 16'd1;
			tlen = 0;
			esc = 1'b0;
		end else if (digit_c(c)) begin
			st_mode = M_NUMBER;
			tlen = 1;
		end else if (alpha_c(c)) begin
			st_mode = M_IDENT;
			kw_mask = '1;
			kw_narrow(0, c);
			tlen = 1;
		end else if (c == "." || op_starter(c)) begin
			st_mode = M_OP1;
			op_first = c;
		end else
			push_tok(K_RESERVED, o, 1, E_NONE);
	endtask

	task automatic lex_one(logic [7:0] c, logic [15:0] o);
		case (st_mode)
			M_IDENT: begin
				if (alpha_c(c) || digit_c(c)) begin
					kw_narrow(tlen, c);
					tlen = sat_inc(tlen);
				end else begin
					close_word();
					start_tok(c, o);
				end
			end
			M_NUMBER: begin
				if (digit_c(c))
					tlen = sat_inc(tlen);
				else if (c == "L" || c == "F") begin
					push_tok(K_NUMBER, tstart, sat_inc(tlen), E_NONE);
					st_mode = M_IDLE;
				end else begin
					push_tok(K_NUMBER, tstart, tlen, E_NONE);
					start_tok(c, o);
				end
			end
			M_DQUOTE, M_SQUOTE: begin
				if (esc) begin
					esc = 1'b0;
					tlen = sat_inc(tlen);
				end else if (c == (st_mode == M_DQUOTE ? "\"" : "'")) begin
					push_tok(st_mode == M_DQUOTE ? K_STRING : K_CHAR, tstart, tlen, E_NONE);
					st_mode = M_IDLE;
				end else begin
					if (c == "\\")
						esc = 1'b1;
					tlen = sat_inc(tlen);
				end
			end
			M_LINECMT: if (c == "\n") start_tok(c, o);
			M_BLOCKCMT: if (c == "*") st_mode = M_BLOCKSTAR;
			M_BLOCKSTAR: begin
				if (c == "/")
					st_mode = M_IDLE;
				else if (c != "*")
					st_mode = M_BLOCKCMT;
			end
			M_SLASH: begin
				if (c == "/")
					st_mode = M_LINECMT;
				else if (c == "*")
					st_mode = M_BLOCKCMT;
				else if (c == "=") begin
					push_tok(K_RESERVED, tstart, 2, E_NONE);
					st_mode = M_IDLE;
				end else begin
					push_tok(K_RESERVED, tstart, 1, E_NONE);
					start_tok(c, o);
				end
			end
			M_BACKSL: begin
				if (c == "\n") begin
					blank = 1'b1;
					st_mode = M_IDLE;
				end else begin
					push_tok(K_RESERVED, tstart, 1, E_NONE);
					start_tok(c, o);
				end
			end
			M_OP1: begin
				if (op_first == "." && c == ".")
					st_mode = M_DOT2;
				else if (op_pair(op_first, c)) begin
					push_tok(K_RESERVED, tstart, 2, E_NONE);
					st_mode = M_IDLE;
				end else begin
					push_tok(K_RESERVED, tstart, 1, E_NONE);
					start_tok(c, o);
				end
			end
			M_DOT2: begin
				if (c == ".") begin
					push_tok(K_RESERVED, tstart, 3, E_NONE);
					st_mode = M_IDLE;
				end else begin
					push_tok(K_RESERVED, tstart, 1, E_NONE);
					push_tok(K_RESERVED, tstart + 16'd1, 1, E_NONE);
					start_tok(c, o);
				end
			end
			default: start_tok(c, o);
		endcase
	endtask

	task automatic lex_finish();
		err_t e;
		e = E_NONE;
		case (st_mode)
			M_IDENT: close_word();
			M_NUMBER: push_tok(K_NUMBER, tstart, tlen, E_NONE);
			M_DQUOTE: push_tok(K_STRING, tstart, tlen, E_QUOTE);
			M_SQUOTE: push_tok(K_CHAR, tstart, tlen, E_QUOTE);
			M_BLOCKCMT, M_BLOCKSTAR: e = E_BLOCKCMT;
			M_SLASH, M_BACKSL, M_OP1: push_tok(K_RESERVED, tstart, 1, E_NONE);
			M_DOT2: begin
				push_tok(K_RESERVED, tstart, 1, E_NONE);
				push_tok(K_RESERVED, tstart + 16'd1, 1, E_NONE);
			end
			default: ;
		endcase
		push_tok(K_EOF, offs, 0, e);
		st_mode = M_IDLE;
		offs = '0;
		blank = 1'b0;
		esc = 1'b0;
		tlen = 0;
		kw_mask = '1;
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		n_fail++;
		$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_rec_t w;
		if (!arst_n) begin
			st_mode = M_IDLE;
			prev_tok = K_NEWLINE;
			tstart = '0;
			tlen = 0;
			blank = 1'b0;
			esc = 1'b0;
			op_first = '0;
			kw_mask = '1;
			offs = '0;
			tokens_due.delete();
			n_fail = 0;
			n_tokens = 0;
			n_texts = 0;
		end else begin
			if (txt.valid && txt.ready) begin
				step_toks.delete();
				if (txt.end_of_text) begin
					lex_finish();
					n_texts++;
				end else begin
					lex_one(txt.text_byte, offs);
					offs = offs + 16'd1;
				end
				if (step_toks.size() > 0)
					step_toks[step_toks.size()-1].last = 1'b1;
				foreach (step_toks[i])
					tokens_due.push_back(step_toks[i]);
			end
			if (tok.valid && tok.ready) begin
				n_tokens++;
				if (tokens_due.size() == 0) begin
					report("unexpected token kind", tok.token_kind, 0);
				end else begin
					w = tokens_due.pop_front();
					if (tok.token_kind !== w.kind)
						report("token_kind", tok.token_kind, w.kind);
					if (tok.start_offset !== w.start)
						report("start_offset", tok.start_offset, w.start);
					if (tok.token_length !== w.len)
						report("token_length", tok.token_length, w.len);
					if (tok.spaces_before !== w.blank)
						report("spaces_before", tok.spaces_before, w.blank);
					if (tok.error_code !== w.err)
						report("error_code", tok.error_code, w.err);
					if (tok.last_of_run !== w.last)
						report("last_of_run", tok.last_of_run, w.last);
				end
			end
		end
	end

endmodule

// ===== tb/c_preprocessor_token_lexer_tb.sv =====
// Testbench top for the C preprocessor token lexer: clock, reset, text stimulus,
// receiver stalls and verdict. Depends on cptl_pkg, cptl_if and cptl_lexer_check.
module c_preprocessor_token_lexer_tb;
	import cptl_pkg::*;

	logic clk;
	logic arst_n;
	int   src_idle;
	int   dst_idle;
	int   stall_left;
	int   n_fail, n_waiting, n_tokens, n_texts, n_bytes;

	cptl_text_if txt();
	cptl_tok_if  tok();

	c_preprocessor_token_lexer dut (.clk(clk), .arst_n(arst_n), .text_in(txt), .tok_out(tok));

	cptl_lexer_check chk (.clk(clk), .arst_n(arst_n), .txt(txt), .tok(tok), .n_fail(n_fail),
		.n_waiting(n_waiting), .n_tokens(n_tokens), .n_texts(n_texts));

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		txt.valid = 1'b0;
		txt.text_byte = '0;
		txt.end_of_text = 1'b0;
		tok.ready = 1'b0;
		stall_left = 0;
		src_idle = 37;
		dst_idle = 48;
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			tok.ready <= 1'b0;
		end else
			tok.ready <= arst_n && ($urandom_range(99) >= dst_idle);
	end

	task automatic send(logic [7:0] b, logic eot);
		while ($urandom_range(99) < src_idle) begin
			txt.valid <= 1'b0;
			@(posedge clk);
		end
		txt.valid <= 1'b1;
		txt.text_byte <= b;
		txt.end_of_text <= eot;
		@(negedge clk);
		while (!txt.ready)
			@(negedge clk);
		@(posedge clk);
		n_bytes++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send(s[i], 1'b0);
	endtask

	task automatic drain();
		txt.valid <= 1'b0;
		@(posedge clk);
		while (n_waiting != 0)
			@(posedge clk);
	endtask

	task automatic rand_piece();
		string kws[13] = '{{"include", "_next"}, "include", "define", "undef", "defined",
			"warning", "error", "ifdef", "ifndef", "if", "else", "elif", "endif"};
		string ops[22] = '{">>", "<<", "==", "!=", "<=", ">=", "--", "++", "&&", "||",
			"+=", "-=", "%=", "/=", "*=", "##", "...", "..", ".", "(", ";", "/"};
		string s;
		int n;
		s = "";
		case ($urandom_range(14))
			0, 1: begin
				if ($urandom_range(1))
					s = kws[$urandom_range(12)];
				else begin
					n = $urandom_range(1, 9);
					s = {s, $urandom_range(1) ? "_" : "x"};
					for (int i = 1; i < n; i++)
						s = {s, string'(8'($urandom_range(1) ? $urandom_range("a", "z") :
							$urandom_range("0", "9")))};
				end
			end
			2: begin
				n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++)
					s = {s, string'(8'($urandom_range("0", "9")))};
				case ($urandom_range(3))
					0: s = {s, "L"};
					1: s = {s, "F"};
					default: ;
				endcase
			end
			3: s = $urandom_range(1) ? "\"a\\\"b\\\\c\"" : "'\\''";
			4: s = ops[$urandom_range(21)];
			5: s = $urandom_range(1) ? "// note x\n" : "/* a ** b */";
			6: s = "\n";
			7: s = "#";
			8: s = $urandom_range(1) ? " " : "\t ";
			9: s = "\\\n";
			10: s = "\\x";
			11: s = {"\"", string'(8'($urandom_range(32, 126))), "\n\""};
			default: ;
		endcase
		if (s.len() == 0)
			send(8'($urandom_range(255)), 1'b0);
		else
			send_text(s);
		if ($urandom_range(29) == 0)
			send(8'($urandom_range(255)), 1'b1);
	endtask

	initial begin
		n_bytes = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text({"#define ifdef 12L x9F 7 \n#include", "_next ## #\n"});
		send(8'd0, 1'b0);
		send(8'd255, 1'b0);
		send(8'd128, 1'b0);
		send_text("a...b..c.d >>= <<!=&&||++--%=*=/=/x\\\n y \\z 'q' \"s\\\"t\"");
		send_text("/*/ * **/ // cmt\nelse elif endif undef error warning ifndef if");
		send(8'd0, 1'b1);
		send_text("..");
		send(8'd0, 1'b1);
		send_text("\"open\nstring");
		send(8'd0, 1'b1);
		send_text("/* never closed *");
		send(8'd0, 1'b1);
		send_text("'c");
		send(8'd0, 1'b1);
		drain();

		while (n_bytes < 215)
			rand_piece();

		src_idle = 48;
		dst_idle = 37;
		stall_left = 80;
		while (n_bytes < 245)
			rand_piece();
		drain();

		src_idle = 0;
		dst_idle = 0;
		while (n_bytes < 268)
			rand_piece();
		send(8'd0, 1'b1);
		drain();
		repeat (20) @(posedge clk);

		$display("covered %0d text items over %0d texts, %0d tokens compared",
			n_bytes, n_texts, n_tokens);
		if (n_fail == 0)
			$display("c_preprocessor_token_lexer_tb: clean");
		else
			$display("c_preprocessor_token_lexer_tb: errors");
		$finish;
	end

	initial begin
		#20000000;
		$display("timeout");
		$display("c_preprocessor_token_lexer_tb: errors");
		$finish;
	end

endmodule
